@@ rtl/fft_pkg.sv @@
// Shared types and constants for the radix-2 complex FFT.
// No dependencies.
`timescale 1ns / 1ps
package fft_pkg;
   localparam int BIN_WIDTH = 24;
   localparam int TW_WIDTH = 16;
   localparam int CSR_ADDR_WIDTH = 3;
   localparam logic [CSR_ADDR_WIDTH-1:0] ADDR_INVERSE = 3'd0;
   localparam logic [CSR_ADDR_WIDTH-1:0] ADDR_LOG2 = 3'd4;

   typedef logic signed [BIN_WIDTH-1:0] bin_type;

   typedef enum logic [5:0] {
      ST_LOAD  = 6'b000001,
      ST_RD_A  = 6'b000010,
      ST_RD_B  = 6'b000100,
      ST_MUL   = 6'b001000,
      ST_WR    = 6'b010000,
      ST_OUT   = 6'b100000
   } state_type;

   function automatic logic [15:0] qsine(input logic [4:0] r);
      case (r)
         5'd0: qsine = 16'd0;     5'd1: qsine = 16'd3212;  5'd2: qsine = 16'd6393;
         5'd3: qsine = 16'd9512;  5'd4: qsine = 16'd12540; 5'd5: qsine = 16'd15447;
         5'd6: qsine = 16'd18205; 5'd7: qsine = 16'd20788; 5'd8: qsine = 16'd23170;
         5'd9: qsine = 16'd25330; 5'd10: qsine = 16'd27246; 5'd11: qsine = 16'd28899;
         5'd12: qsine = 16'd30274; 5'd13: qsine = 16'd31357; 5'd14: qsine = 16'd32138;
         5'd15: qsine = 16'd32610; 5'd16: qsine = 16'd32767;
         default: qsine = 16'd0;
      endcase
   endfunction

   // twiddle for table index m (0..63), sine negated for inverse
   function automatic logic signed [33:0] twiddle(input logic [5:0] m, input logic inv);
      logic signed [16:0] c, s, a, b;
      a = $signed({1'b0, qsine({1'b0, m[3:0]})});
      b = $signed({1'b0, qsine(5'd16 - {1'b0, m[3:0]})});
      case (m[5:4])
         2'd0: begin c = b; s = a; end
         2'd1: begin c = -a; s = b; end
         2'd2: begin c = -b; s = -a; end
         default: begin c = a; s = -b; end
      endcase
      if (inv) s = -s;
      twiddle = {c, s};
   endfunction

   function automatic bin_type sat24(input logic signed [BIN_WIDTH+1:0] v);
      if (v > 26'sd8388607) sat24 = 24'sh7fffff;
      else if (v < -26'sd8388608) sat24 = 24'sh800000;
      else sat24 = v[BIN_WIDTH-1:0];
   endfunction
endpackage

@@ rtl/fft_stream_if.sv @@
// Valid/ready channel interface carrying a parameterized payload.
// No dependencies.
`timescale 1ns / 1ps
interface fft_stream_if #(parameter int WIDTH = 32);
   logic valid;
   logic ready;
   logic [WIDTH-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ rtl/fft_csr.sv @@
// APB-style register file: inverse_mode and log2_points.
// Depends on fft_pkg.
`timescale 1ns / 1ps
module fft_csr (
   input  logic clock,
   input  logic reset,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [fft_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready,
   output logic inverse_mode,
   output logic [2:0] log2_points
);
   import fft_pkg::*;
   logic inv_ff, inv_in;
   logic [2:0] log_ff, log_in;
   logic wr;
   assign wr = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   always_comb begin
      inv_in = inv_ff;
      log_in = log_ff;
      if (wr && csr_paddr == ADDR_INVERSE) inv_in = csr_pwdata[0];
      if (wr && csr_paddr == ADDR_LOG2) log_in = csr_pwdata[2:0];
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         inv_ff <= 1'b0;
         log_ff <= 3'd6;
      end else begin
         inv_ff <= inv_in;
         log_ff <= log_in;
      end
   end
   always_comb begin
      csr_prdata = 32'd0;
      if (csr_paddr == ADDR_INVERSE) csr_prdata = {31'd0, inv_ff};
      else if (csr_paddr == ADDR_LOG2) csr_prdata = {29'd0, log_ff};
   end
   assign inverse_mode = inv_ff;
   assign log2_points = log_ff;
endmodule

@@ rtl/fft_butterfly.sv @@
// Registered radix-2 butterfly: complex multiply, round, add/sub, saturate.
// Depends on fft_pkg.
`timescale 1ns / 1ps
module fft_butterfly (
   input  logic clock,
   input  logic mul_en,
   input  fft_pkg::bin_type a_re,
   input  fft_pkg::bin_type a_im,
   input  fft_pkg::bin_type b_re,
   input  fft_pkg::bin_type b_im,
   input  logic signed [16:0] w_re,
   input  logic signed [16:0] w_im,
   output fft_pkg::bin_type x_re,
   output fft_pkg::bin_type x_im,
   output fft_pkg::bin_type y_re,
   output fft_pkg::bin_type y_im
);
   import fft_pkg::*;
   logic signed [41:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff;
   logic signed [42:0] vr_full, vi_full;
   logic signed [25:0] vr, vi;
   always_ff @(posedge clock) begin
      if (mul_en) begin
         p_rr_ff <= b_re * w_re;
         p_ii_ff <= b_im * w_im;
         p_ri_ff <= b_re * w_im;
         p_ir_ff <= b_im * w_re;
      end
   end
   assign vr_full = (43'(p_rr_ff) - 43'(p_ii_ff) + 43'sd16384) >>> 15;
   assign vi_full = (43'(p_ri_ff) + 43'(p_ir_ff) + 43'sd16384) >>> 15;
   assign vr = vr_full[25:0];
   assign vi = vi_full[25:0];
   assign x_re = sat24(26'(a_re) + vr);
   assign x_im = sat24(26'(a_im) + vi);
   assign y_re = sat24(26'(a_re) - vr);
   assign y_im = sat24(26'(a_im) - vi);
endmodule

@@ rtl/radix2_complex_fft.sv @@
// Top level of the radix-2 complex FFT: sequencer, frame memory, ports.
// Depends on fft_pkg, fft_stream_if, fft_csr, fft_butterfly.
`timescale 1ns / 1ps
// Loads n = 2^L samples (L from log2_points, clamped to 1..min(log2(MAX_POINTS), 6)),
// one per transfer, into bit-reversed slots of a frame memory with one read and one write port.
// After the last sample the request side stalls while one shared butterfly
// unit runs (n/2)*L butterflies, each as two memory reads, a multiply and a
// write, then n bins stream out in natural order when the sink is ready, each
// read from memory into the output register before the next is fetched,
// last_bin on bin n-1.
module radix2_complex_fft #(
   parameter int MAX_POINTS = 64,
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic clock,
   input  logic reset,
   fft_stream_if.sink req,
   fft_stream_if.source rsp,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [fft_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);
   import fft_pkg::*;
   localparam int AW = $clog2(MAX_POINTS);
   localparam int FLOG = $clog2(MAX_POINTS + 1) - 1;
   localparam int MAXLOG = (FLOG > 6) ? 6 : FLOG;

   logic inverse_mode;
   logic [2:0] log2_points;
   fft_csr u_csr (.clock, .reset, .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr,
      .csr_pwdata, .csr_prdata, .csr_pready, .inverse_mode, .log2_points);

   logic [2:0] lg;
   always_comb begin
      lg = log2_points;
      if (lg < 3'd1) lg = 3'd1;
      if (lg > 3'(MAXLOG)) lg = 3'(MAXLOG);
   end
   logic [AW:0] npts;
   assign npts = (AW+1)'(1) << lg;

   state_type state_ff, state_in;
   logic [AW:0] cnt_ff, cnt_in;          // load count / output index
   logic [2:0] stage_ff, stage_in;       // stage s: half = 2^s
   logic [AW-1:0] bf_ff, bf_in;          // butterfly index within stage
   logic inv_ff, inv_in;
   logic [2:0] lg_ff, lg_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic last_ff;

   bin_type mem_re [MAX_POINTS];
   bin_type mem_im [MAX_POINTS];
   bin_type rd_re_ff, rd_im_ff, a_re_ff, a_im_ff;
   logic signed [16:0] w_re_ff, w_im_ff;

   // butterfly addresses
   logic [AW-1:0] j_idx, hmask, addr_a, addr_b, base;
   logic [AW-1:0] one_a;
   assign one_a = AW'(1);
   assign hmask = (one_a << stage_ff) - one_a;
   assign j_idx = bf_ff & hmask;
   assign base = (bf_ff & ~hmask) << 1;
   assign addr_a = base | j_idx;
   assign addr_b = addr_a | (one_a << stage_ff);

   // a count left over from a longer frame restarts the load
   logic [AW:0] load_idx;
   assign load_idx = (cnt_ff >= npts) ? '0 : cnt_ff;

   logic [AW-1:0] brev;
   always_comb begin
      brev = '0;
      for (int i = 0; i < AW; i++)
         if (i < int'(lg)) brev[int'(lg) - 1 - i] = load_idx[i];
   end

   logic [5:0] tw_m;
   logic [6:0] tw_full;
   assign tw_full = 7'(j_idx) << (3'd5 - stage_ff);
   assign tw_m = tw_full[5:0];

   logic [BIN_WIDTH-1:0] raw_re, raw_im;
   bin_type in_re, in_im;
   assign raw_re = {8'd0, req.data[15:0]};
   assign raw_im = {8'd0, req.data[31:16]};
   assign in_re = BIN_WIDTH'($signed(raw_re[SAMPLE_WIDTH-1:0]));
   assign in_im = BIN_WIDTH'($signed(raw_im[SAMPLE_WIDTH-1:0]));

   bin_type x_re, x_im, y_re, y_im;
   fft_butterfly u_bfly (.clock, .mul_en(state_ff == ST_MUL), .a_re(a_re_ff), .a_im(a_im_ff),
      .b_re(rd_re_ff), .b_im(rd_im_ff), .w_re(w_re_ff), .w_im(w_im_ff),
      .x_re, .x_im, .y_re, .y_im);

   logic req_xfer, rsp_xfer, last_bf, out_advance;
   logic out_rd_ff;
   assign req.ready = (state_ff == ST_LOAD);
   assign req_xfer = req.valid & req.ready;
   assign rsp_xfer = rsp_valid_ff & rsp.ready;
   assign last_bf = (stage_ff == lg_ff - 3'd1) &&
                    (bf_ff == AW'((npts >> 1) - (AW+1)'(1)));
   assign out_advance = (state_ff == ST_OUT) && !out_rd_ff && (!rsp_valid_ff || rsp.ready)
                        && (cnt_ff != npts);

   // b result is written in the cycle after a, through a holding reg
   bin_type yb_re_ff, yb_im_ff;
   logic [AW-1:0] yb_addr_ff;
   logic yb_pend_ff;
   always_ff @(posedge clock) begin
      if (state_ff == ST_WR) begin
         yb_re_ff <= y_re; yb_im_ff <= y_im; yb_addr_ff <= addr_b;
      end
   end

   // memory read address and write
   logic [AW-1:0] rd_addr;
   always_comb begin
      rd_addr = addr_a;
      if (state_ff == ST_RD_B) rd_addr = addr_b;
      else if (state_ff == ST_OUT) rd_addr = cnt_ff[AW-1:0];
   end
   // pending b write uses the write port during the following RD_A (or first OUT)
   // slot; the next butterfly's a address never equals yb_addr, and its b read follows this write.
   always_ff @(posedge clock) begin
      rd_re_ff <= mem_re[rd_addr];
      rd_im_ff <= mem_im[rd_addr];
      if (req_xfer) begin
         mem_re[brev] <= in_re;
         mem_im[brev] <= in_im;
      end else if (state_ff == ST_WR) begin
         mem_re[addr_a] <= x_re;
         mem_im[addr_a] <= x_im;
      end else if (yb_pend_ff) begin
         mem_re[yb_addr_ff] <= yb_re_ff;
         mem_im[yb_addr_ff] <= yb_im_ff;
      end
   end

   always_comb begin
      state_in = state_ff; cnt_in = cnt_ff; stage_in = stage_ff; bf_in = bf_ff;
      inv_in = inv_ff; lg_in = lg_ff; rsp_valid_in = rsp_valid_ff;
      if (rsp_xfer) rsp_valid_in = 1'b0;
      case (state_ff)
         ST_LOAD: if (req_xfer) begin
            if (load_idx + (AW+1)'(1) >= npts) begin
               cnt_in = '0; stage_in = '0; bf_in = '0;
               inv_in = inverse_mode; lg_in = lg; state_in = ST_RD_A;
            end else cnt_in = load_idx + (AW+1)'(1);
         end
         ST_RD_A: state_in = ST_RD_B;
         ST_RD_B: state_in = ST_MUL;
         ST_MUL: state_in = ST_WR;
         ST_WR: begin
            if (last_bf) begin
               state_in = ST_OUT; cnt_in = '0;
            end else begin
               state_in = ST_RD_A;
               if (bf_ff == AW'((npts >> 1) - (AW+1)'(1))) begin
                  bf_in = '0; stage_in = stage_ff + 3'd1;
               end else bf_in = bf_ff + AW'(1);
            end
         end
         ST_OUT: begin
            if (cnt_ff == npts && !out_rd_ff && !rsp_valid_in) begin
               state_in = ST_LOAD; cnt_in = '0;
            end else if (out_advance) cnt_in = cnt_ff + (AW+1)'(1);
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // output register fed by registered memory read
   logic out_last_ff;
   bin_type out_re_ff, out_im_ff;
   bin_type sh_re, sh_im;
   assign sh_re = inv_ff ? (rd_re_ff >>> lg_ff) : rd_re_ff;
   assign sh_im = inv_ff ? (rd_im_ff >>> lg_ff) : rd_im_ff;

   always_ff @(posedge clock) begin
      if (state_ff == ST_RD_B) begin a_re_ff <= rd_re_ff; a_im_ff <= rd_im_ff; end
      if (state_ff == ST_RD_B) {w_re_ff, w_im_ff} <= twiddle(tw_m, inv_ff);
      if (out_rd_ff) begin
         out_re_ff <= sh_re; out_im_ff <= sh_im; out_last_ff <= last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD; cnt_ff <= '0; stage_ff <= '0; bf_ff <= '0;
         inv_ff <= 1'b0; lg_ff <= 3'd1; rsp_valid_ff <= 1'b0; last_ff <= 1'b0;
         out_rd_ff <= 1'b0; yb_pend_ff <= 1'b0;
      end else begin
         state_ff <= state_in; cnt_ff <= cnt_in; stage_ff <= stage_in; bf_ff <= bf_in;
         inv_ff <= inv_in; lg_ff <= lg_in;
         yb_pend_ff <= (state_ff == ST_WR);
         out_rd_ff <= out_advance;
         last_ff <= (cnt_ff == npts - (AW+1)'(1));
         rsp_valid_ff <= out_rd_ff ? 1'b1 : rsp_valid_in;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.data = {out_last_ff, out_im_ff, out_re_ff};
endmodule
